// ===== design/ht4_pkg.sv =====
// shared constants, types and sine table for the 4x4 transform unit
package ht4_pkg;

  localparam int FRAC_BITS = 16;

  localparam logic [2:0] OP_LOAD      = 3'd0;
  localparam logic [2:0] OP_ROTATE    = 3'd1;
  localparam logic [2:0] OP_TRANSLATE = 3'd2;
  localparam logic [2:0] OP_XFORM     = 3'd3;
  localparam logic [2:0] OP_READ      = 3'd4;

  localparam logic signed [31:0] S32_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] S32_MIN = -32'sh7fffffff - 32'sd1;
  localparam logic signed [31:0] ONE_FX  = 32'sd1 <<< FRAC_BITS;

  // one lane operand pair
  typedef struct packed {
    logic signed [31:0] a;
    logic signed [31:0] b;
  } lane_in_t;

  // fixed-point product, floor shift (arithmetic shift floors)
  function automatic logic signed [47:0] fmul(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    logic signed [63:0] p;
    p = 64'(a) * 64'(b);
    return 48'(p >>> FRAC_BITS);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
    if (v > 50'(S32_MAX)) return S32_MAX;
    else if (v < 50'(S32_MIN)) return S32_MIN;
    else return 32'(v);
  endfunction

  // sin of 0..90 degrees rounded, unsigned Q1.16
  function automatic logic [16:0] sin_q1(input logic [6:0] d);
    logic [16:0] t [0:90];
    t = '{17'd0, 17'd1144, 17'd2287, 17'd3430, 17'd4572, 17'd5712, 17'd6850,
          17'd7987, 17'd9121, 17'd10252, 17'd11380, 17'd12505, 17'd13626,
          17'd14742, 17'd15855, 17'd16962, 17'd18064, 17'd19161, 17'd20252,
          17'd21336, 17'd22415, 17'd23486, 17'd24550, 17'd25607, 17'd26656,
          17'd27697, 17'd28729, 17'd29753, 17'd30767, 17'd31772, 17'd32768,
          17'd33754, 17'd34729, 17'd35693, 17'd36647, 17'd37590, 17'd38521,
          17'd39441, 17'd40348, 17'd41243, 17'd42126, 17'd42995, 17'd43852,
          17'd44695, 17'd45525, 17'd46341, 17'd47143, 17'd47930, 17'd48703,
          17'd49461, 17'd50203, 17'd50931, 17'd51643, 17'd52339, 17'd53020,
          17'd53684, 17'd54332, 17'd54963, 17'd55578, 17'd56175, 17'd56756,
          17'd57319, 17'd57865, 17'd58393, 17'd58903, 17'd59396, 17'd59870,
          17'd60326, 17'd60764, 17'd61183, 17'd61584, 17'd61966, 17'd62328,
          17'd62672, 17'd62997, 17'd63303, 17'd63589, 17'd63856, 17'd64104,
          17'd64332, 17'd64540, 17'd64729, 17'd64898, 17'd65048, 17'd65177,
          17'd65287, 17'd65376, 17'd65446, 17'd65496, 17'd65526, 17'd65536};
    return (d > 7'd90) ? 17'd0 : t[d];
  endfunction

  // sin of any 10-bit angle, reduced modulo 360
  function automatic logic signed [31:0] sin_deg(input logic [9:0] a_in);
    logic [9:0] a;
    a = (a_in >= 10'd720) ? a_in - 10'd720 :
        (a_in >= 10'd360) ? a_in - 10'd360 : a_in;
    if (a <= 10'd90) return 32'(sin_q1(7'(a)));
    else if (a <= 10'd180) return 32'(sin_q1(7'(10'd180 - a)));
    else if (a <= 10'd270) return -32'(sin_q1(7'(a - 10'd180)));
    else return -32'(sin_q1(7'(10'd360 - a)));
  endfunction

endpackage

// ===== design/ht4_lane.sv =====
// one multiply lane: registered fixed-point product
module ht4_lane import ht4_pkg::*; (
  input  logic               clk,
  input  lane_in_t           opnd,
  output logic signed [47:0] prod
);

  // product register
  always_ff @(posedge clk) begin
    prod <= fmul(opnd.a, opnd.b);
  end

endmodule

// ===== design/ht4_merge.sv =====
// merging stage: sums four lane products and saturates
module ht4_merge import ht4_pkg::*; (
  input  logic signed [47:0] p0,
  input  logic signed [47:0] p1,
  input  logic signed [47:0] p2,
  input  logic signed [47:0] p3,
  output logic signed [31:0] sum
);

  // exact sum then clamp
  always_comb begin
    sum = sat32(50'(p0) + 50'(p1) + 50'(p2) + 50'(p3));
  end

endmodule

// ===== design/homogeneous_transform_4x4_unit.sv =====
// top level of the 4x4 homogeneous transform unit
// One transaction is taken when start is high and busy is low. Load element and read
// row never raise busy, so a new transaction can follow on the next cycle; read row
// presents its row on the cycle after acceptance. Transform vector holds busy while
// the four lanes form one row's products per cycle and the merge stage sums the
// registered products; the result comes on the first cycle after busy falls. Translate
// holds busy while the 16 result elements go through the four lanes one per cycle,
// and then drain through the merge stage. Rotate holds busy in S_TRIG, which clears the
// rotation matrix after the table lookup at acceptance, then in S_ROT, which forms the
// rotation entries through the lanes, then through the same matrix product. Results appear
// for one cycle with done high and cannot be stalled.
module homogeneous_transform_4x4_unit import ht4_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  output logic               done,
  input  logic [2:0]         op,
  input  logic [1:0]         row,
  input  logic [1:0]         col,
  input  logic signed [31:0] value,
  input  logic [8:0]         angle_x,
  input  logic [8:0]         angle_y,
  input  logic [8:0]         angle_z,
  input  logic signed [31:0] vec_x,
  input  logic signed [31:0] vec_y,
  input  logic signed [31:0] vec_z,
  input  logic signed [31:0] vec_w,
  output logic signed [31:0] out_0,
  output logic signed [31:0] out_1,
  output logic signed [31:0] out_2,
  output logic signed [31:0] out_3
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_TRIG  = 3'd1;
  localparam logic [2:0] S_ROT   = 3'd2;
  localparam logic [2:0] S_MUL   = 3'd3;
  localparam logic [2:0] S_XFORM = 3'd4;

  logic [2:0]         state;
  logic [2:0]         step;
  logic [1:0]         wr_cnt;
  logic               wr_pend;
  logic [1:0]         wr_row;
  logic [1:0]         iss_row;
  logic signed [31:0] mat [0:15];
  logic signed [31:0] bm  [0:15];
  logic signed [31:0] cx, sx, cy, sy, cz, sz, sxsy, cxsy;
  logic signed [31:0] vx, vy, vz, vw;
  lane_in_t           lane_in [0:3];
  logic signed [47:0] prod    [0:3];
  logic signed [31:0] msum;
  logic signed [31:0] rowbuf  [0:3];

  // four parallel lanes
  for (genvar g = 0; g < 4; g++) begin : g_lane
    ht4_lane u_lane (.clk(clk), .opnd(lane_in[g]), .prod(prod[g]));
  end

  ht4_merge u_merge (.p0(prod[0]), .p1(prod[1]), .p2(prod[2]), .p3(prod[3]),
                     .sum(msum));

  assign busy = (state != S_IDLE);

  // issue row runs one ahead of the write-back row once a row completes
  assign iss_row = (wr_pend && wr_cnt == 2'd3) ? wr_row + 2'd1 : wr_row;

  // lane operand selection
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      lane_in[k].a = '0;
      lane_in[k].b = '0;
    end
    unique case (state)
      S_ROT: begin
        unique case (step)
          3'd0: begin
            lane_in[0] = '{sx, sy};
            lane_in[1] = '{cx, sy};
            lane_in[2] = '{cy, cz};
            lane_in[3] = '{cy, sz};
          end
          3'd1: begin
            // sx*sy and cx*sy straight from the lane registers
            lane_in[0] = '{cx, sz};
            lane_in[1] = '{32'(prod[0]), cz};
            lane_in[2] = '{sx, sz};
            lane_in[3] = '{32'(prod[1]), cz};
          end
          3'd2: begin
            lane_in[0] = '{cx, cz};
            lane_in[1] = '{sxsy, sz};
            lane_in[2] = '{sx, cz};
            lane_in[3] = '{cxsy, sz};
          end
          default: begin
            lane_in[0] = '{sx, cy};
            lane_in[1] = '{cx, cy};
          end
        endcase
      end
      S_MUL: begin
        // element (iss_row, step) of the product, one term per lane
        for (int k = 0; k < 4; k++) begin
          lane_in[k].a = mat[{iss_row, 2'(k)}];
          lane_in[k].b = bm[{2'(k), step[1:0]}];
        end
      end
      S_XFORM: begin
        lane_in[0] = '{vx, mat[{step[1:0], 2'd0}]};
        lane_in[1] = '{vy, mat[{step[1:0], 2'd1}]};
        lane_in[2] = '{vz, mat[{step[1:0], 2'd2}]};
        lane_in[3] = '{vw, mat[{step[1:0], 2'd3}]};
      end
      default: ;
    endcase
  end

  // control sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
      step  <= '0;
      wr_pend <= 1'b0;
      for (int k = 0; k < 16; k++)
        mat[k] <= (k % 5 == 0) ? ONE_FX : '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            vx <= vec_x; vy <= vec_y; vz <= vec_z; vw <= vec_w;
            step <= '0;
            unique case (op)
              OP_LOAD: mat[{row, col}] <= value;
              OP_ROTATE: begin
                cx <= sin_deg(10'(angle_x) + 10'd90); sx <= sin_deg(10'(angle_x));
                cy <= sin_deg(10'(angle_y) + 10'd90); sy <= sin_deg(10'(angle_y));
                cz <= sin_deg(10'(angle_z) + 10'd90); sz <= sin_deg(10'(angle_z));
                state <= S_TRIG;
              end
              OP_TRANSLATE: begin
                for (int k = 0; k < 16; k++)
                  bm[k] <= (k % 5 == 0) ? ONE_FX : '0;
                bm[3] <= vec_x; bm[7] <= vec_y; bm[11] <= vec_z;
                wr_row <= '0; wr_cnt <= '0; wr_pend <= 1'b0;
                state <= S_MUL;
              end
              OP_XFORM: state <= S_XFORM;
              OP_READ: begin
                out_0 <= mat[{row, 2'd0}]; out_1 <= mat[{row, 2'd1}];
                out_2 <= mat[{row, 2'd2}]; out_3 <= mat[{row, 2'd3}];
                done  <= 1'b1;
              end
              default: ;
            endcase
          end
        end
        S_TRIG: begin
          for (int k = 0; k < 16; k++) bm[k] <= '0;
          bm[8]  <= sat32(-50'(sy));
          bm[15] <= ONE_FX;
          state  <= S_ROT;
        end
        S_ROT: begin
          // lane products land in the cycle after issue
          step <= step + 3'd1;
          unique case (step)
            3'd0: ;
            3'd1: begin
              sxsy <= 32'(prod[0]); cxsy <= 32'(prod[1]);
              bm[0] <= sat32(50'(prod[2])); bm[4] <= sat32(50'(prod[3]));
            end
            3'd2: begin
              bm[1] <= sat32(50'(prod[1]) - 50'(prod[0]));
              bm[2] <= sat32(50'(prod[2]) + 50'(prod[3]));
            end
            3'd3: begin
              bm[5] <= sat32(50'(prod[0]) + 50'(prod[1]));
              bm[6] <= sat32(50'(prod[3]) - 50'(prod[2]));
            end
            default: begin
              bm[9]  <= sat32(50'(prod[0]));
              bm[10] <= sat32(50'(prod[1]));
              wr_row <= '0; wr_cnt <= '0; wr_pend <= 1'b0;
              step   <= '0;
              state  <= S_MUL;
            end
          endcase
        end
        S_MUL: begin
          // one element per cycle, results buffered per row
          if (wr_pend) rowbuf[wr_cnt] <= msum;
          if (wr_pend && wr_cnt == 2'd3) begin
            mat[{wr_row, 2'd0}] <= rowbuf[0];
            mat[{wr_row, 2'd1}] <= rowbuf[1];
            mat[{wr_row, 2'd2}] <= rowbuf[2];
            mat[{wr_row, 2'd3}] <= msum;
            wr_row <= wr_row + 2'd1;
            if (wr_row == 2'd3) state <= S_IDLE;
          end
          wr_cnt  <= step[1:0];
          wr_pend <= 1'b1;
          step    <= {1'b0, step[1:0] + 2'd1};
        end
        S_XFORM: begin
          if (step != '0) rowbuf[2'(step - 3'd1)] <= msum;
          step <= step + 3'd1;
          if (step == 3'd4) begin
            out_0 <= rowbuf[0]; out_1 <= rowbuf[1];
            out_2 <= rowbuf[2]; out_3 <= msum;
            done  <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== dv/ht4_checker.sv =====
// transaction monitor, matrix predictor and result comparison for the 4x4 transform unit
module ht4_checker import ht4_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  logic               done,
  input  logic [2:0]         op,
  input  logic [1:0]         row,
  input  logic [1:0]         col,
  input  logic signed [31:0] value,
  input  logic [8:0]         angle_x,
  input  logic [8:0]         angle_y,
  input  logic [8:0]         angle_z,
  input  logic signed [31:0] vec_x,
  input  logic signed [31:0] vec_y,
  input  logic signed [31:0] vec_z,
  input  logic signed [31:0] vec_w,
  input  logic signed [31:0] out_0,
  input  logic signed [31:0] out_1,
  input  logic signed [31:0] out_2,
  input  logic signed [31:0] out_3,
  output int                 fail_count,
  output int                 rows_pending,
  output int                 rows_seen
);

  typedef struct {
    logic signed [31:0] c [4];
  } quad_t;

  quad_t   expected_rows [$];
  longint  mat [16];
  longint  sine_tab [0:90];

  // q30 multiply with rounding
  function automatic longint unsigned q30_mul(longint unsigned a, longint unsigned b);
    return (a * b + 64'd536870912) >> 30;
  endfunction

  // sine of 0..90 degrees by taylor series at 30 fraction bits
  function automatic longint quadrant_sine(int d);
    longint unsigned x, x2, term;
    longint s;
    x = (longint'(d) * 64'd3373259426 + 64'd90) / 64'd180;
    x2 = q30_mul(x, x);
    term = x;
    s = x;
    for (int n = 1; n <= 12; n++) begin
      term = q30_mul(term, x2) / (longint'(2 * n) * longint'(2 * n + 1));
      if (n % 2 == 1) s = s - longint'(term);
      else s = s + longint'(term);
    end
    if (s < 0) s = 0;
    if (s > (64'sd1 << 30)) s = 64'sd1 << 30;
    return (s + (64'sd1 << (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
  endfunction

  function automatic longint sine_of(int a);
    a = a % 360;
    if (a <= 90) return sine_tab[a];
    else if (a <= 180) return sine_tab[180 - a];
    else if (a <= 270) return -sine_tab[a - 180];
    else return -sine_tab[360 - a];
  endfunction

  function automatic longint cosine_of(int a);
    return sine_of((a % 360) + 90);
  endfunction

  // floor-shifted fixed-point product
  function automatic longint fx_mul(longint a, longint b);
    longint p;
    p = a * b;
    return p >>> FRAC_BITS;
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // matrix = matrix * b
  task automatic right_mul(input longint b [16]);
    longint r [16];
    longint acc;
    for (int i = 0; i < 4; i++)
      for (int j = 0; j < 4; j++) begin
        acc = 0;
        for (int k = 0; k < 4; k++) acc += fx_mul(mat[i*4+k], b[k*4+j]);
        r[i*4+j] = clamp32(acc);
      end
    mat = r;
  endtask

  // apply one accepted transaction to the predicted matrix
  task automatic predict(input logic [2:0] o, input logic [1:0] r, input logic [1:0] c,
                         input longint val, input int ax, input int ay, input int az,
                         input longint v [4]);
    longint m [16];
    longint cx, sx, cy, sy, cz, sz, sxsy, cxsy, acc;
    quad_t q;
    for (int i = 0; i < 16; i++) m[i] = 0;
    case (o)
      OP_LOAD: begin
        mat[r*4+c] = val;
      end
      OP_ROTATE: begin
        cx = cosine_of(ax); sx = sine_of(ax);
        cy = cosine_of(ay); sy = sine_of(ay);
        cz = cosine_of(az); sz = sine_of(az);
        sxsy = fx_mul(sx, sy);
        cxsy = fx_mul(cx, sy);
        m[0]  = clamp32(fx_mul(cy, cz));
        m[1]  = clamp32(-fx_mul(cx, sz) + fx_mul(sxsy, cz));
        m[2]  = clamp32(fx_mul(sx, sz) + fx_mul(cxsy, cz));
        m[4]  = clamp32(fx_mul(cy, sz));
        m[5]  = clamp32(fx_mul(cx, cz) + fx_mul(sxsy, sz));
        m[6]  = clamp32(-fx_mul(sx, cz) + fx_mul(cxsy, sz));
        m[8]  = clamp32(-sy);
        m[9]  = clamp32(fx_mul(sx, cy));
        m[10] = clamp32(fx_mul(cx, cy));
        m[15] = 64'sd1 << FRAC_BITS;
        right_mul(m);
      end
      OP_TRANSLATE: begin
        m[0] = 64'sd1 << FRAC_BITS; m[5] = m[0]; m[10] = m[0]; m[15] = m[0];
        m[3] = v[0]; m[7] = v[1]; m[11] = v[2];
        right_mul(m);
      end
      OP_XFORM: begin
        for (int i = 0; i < 4; i++) begin
          acc = 0;
          for (int k = 0; k < 4; k++) acc += fx_mul(v[k], mat[i*4+k]);
          q.c[i] = 32'(clamp32(acc));
        end
        expected_rows.push_back(q);
      end
      OP_READ: begin
        for (int i = 0; i < 4; i++) q.c[i] = 32'(mat[r*4+i]);
        expected_rows.push_back(q);
      end
      default: ;
    endcase
  endtask

  initial begin
    for (int d = 0; d <= 90; d++) sine_tab[d] = quadrant_sine(d);
    fail_count = 0;
    rows_seen = 0;
    rows_pending = 0;
  end

  // compare results first, then take in the new transaction
  always @(posedge clk) begin
    quad_t exp_q;
    logic signed [31:0] got [4];
    longint vv [4];
    bit bad;
    if (rst) begin
      for (int i = 0; i < 16; i++) mat[i] = (i % 5 == 0) ? (64'sd1 << FRAC_BITS) : 0;
      expected_rows.delete();
    end else begin
      if (done) begin
        rows_seen++;
        got[0] = out_0; got[1] = out_1; got[2] = out_2; got[3] = out_3;
        if (expected_rows.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected result %0d %0d %0d %0d", out_0, out_1, out_2, out_3);
        end else begin
          exp_q = expected_rows.pop_front();
          bad = 0;
          for (int i = 0; i < 4; i++) if (got[i] !== exp_q.c[i]) bad = 1;
          if (bad) begin
            fail_count++;
            if (fail_count <= 10)
              $display("result mismatch: expected %0d %0d %0d %0d, got %0d %0d %0d %0d",
                       exp_q.c[0], exp_q.c[1], exp_q.c[2], exp_q.c[3],
                       out_0, out_1, out_2, out_3);
          end
        end
      end
      if (start && !busy) begin
        vv[0] = vec_x; vv[1] = vec_y; vv[2] = vec_z; vv[3] = vec_w;
        predict(op, row, col, value, angle_x, angle_y, angle_z, vv);
      end
    end
    rows_pending = expected_rows.size();
  end

endmodule

// ===== dv/homogeneous_transform_4x4_unit_tb.sv =====
// stimulus and verdict for the 4x4 homogeneous transform unit
module homogeneous_transform_4x4_unit_tb;
  import ht4_pkg::*;

  logic               clk = 0;
  logic               rst = 1;
  logic               start = 0;
  logic               busy, done;
  logic [2:0]         op = OP_LOAD;
  logic [1:0]         row = 0, col = 0;
  logic signed [31:0] value = 0;
  logic [8:0]         angle_x = 0, angle_y = 0, angle_z = 0;
  logic signed [31:0] vec_x = 0, vec_y = 0, vec_z = 0, vec_w = 0;
  logic signed [31:0] out_0, out_1, out_2, out_3;
  int                 fail_count, rows_pending, rows_seen;
  int                 cycles = 0;
  int                 sent = 0;

  localparam int CYCLE_LIMIT = 400000;

  homogeneous_transform_4x4_unit DUT (.*);

  ht4_checker u_checker (.*);

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // present one transaction and hold it until taken
  task automatic issue(input logic [2:0] o, input logic [1:0] r, input logic [1:0] c,
                       input logic [31:0] val, input logic [8:0] ax, input logic [8:0] ay,
                       input logic [8:0] az, input logic [31:0] x, input logic [31:0] y,
                       input logic [31:0] z, input logic [31:0] w);
    start <= 1; op <= o; row <= r; col <= c; value <= val;
    angle_x <= ax; angle_y <= ay; angle_z <= az;
    vec_x <= x; vec_y <= y; vec_z <= z; vec_w <= w;
    do @(posedge clk); while (busy);
    sent++;
  endtask

  task automatic idle(input int n);
    start <= 0;
    repeat (n) @(posedge clk);
  endtask

  // mostly modest fixed-point values, sometimes any pattern or an extreme
  function automatic logic [31:0] fx_val();
    case ($urandom_range(0, 9))
      0, 1:    return $urandom;
      2:       return 32'h7fffffff;
      3:       return 32'h80000000;
      default: return 32'($signed($urandom_range(0, 262144)) - 131072);
    endcase
  endfunction

  task automatic random_item();
    int k;
    logic [1:0] r, c;
    logic [8:0] ax, ay, az;
    k = $urandom_range(0, 99);
    r = 2'($urandom);
    c = 2'($urandom);
    ax = 9'($urandom);
    ay = 9'($urandom);
    az = 9'($urandom);
    if (k < 25)
      issue(OP_LOAD, r, c, fx_val(), ax, ay, az,
            $urandom, $urandom, $urandom, $urandom);
    else if (k < 45)
      issue(OP_ROTATE, r, c, $urandom, ax, ay, az,
            $urandom, $urandom, $urandom, $urandom);
    else if (k < 58)
      issue(OP_TRANSLATE, r, c, $urandom, ax, ay, az,
            fx_val(), fx_val(), fx_val(), $urandom);
    else if (k < 78)
      issue(OP_XFORM, r, c, $urandom, ax, ay, az,
            fx_val(), fx_val(), fx_val(), fx_val());
    else if (k < 95)
      issue(OP_READ, r, c, $urandom, ax, ay, az,
            $urandom, $urandom, $urandom, $urandom);
    else
      issue(3'($urandom_range(5, 7)), r, c, $urandom, ax, ay, az,
            $urandom, $urandom, $urandom, $urandom);
  endtask

  initial begin
    int burst, wait_n;
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: read identity, element extremes, rotations over quadrant edges
    issue(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    issue(OP_XFORM, 0, 0, 0, 0, 0, 0, 32'h7fffffff, 32'h80000000, 32'h00010000,
          32'hffffffff);
    issue(OP_LOAD, 3, 3, 32'h7fffffff, 0, 0, 0, 0, 0, 0, 0);
    issue(OP_LOAD, 0, 1, 32'h80000000, 0, 0, 0, 0, 0, 0, 0);
    issue(OP_XFORM, 0, 0, 0, 0, 0, 0, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
          32'h7fffffff);
    issue(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    issue(OP_READ, 3, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    issue(OP_LOAD, 3, 3, ONE_FX, 0, 0, 0, 0, 0, 0, 0);
    issue(OP_LOAD, 0, 1, 0, 0, 0, 0, 0, 0, 0, 0);
    issue(OP_ROTATE, 0, 0, 0, 90, 180, 270, 0, 0, 0, 0);
    issue(OP_READ, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    issue(OP_ROTATE, 0, 0, 0, 359, 360, 511, 0, 0, 0, 0);
    issue(OP_ROTATE, 0, 0, 0, 45, 30, 1, 0, 0, 0, 0);
    issue(OP_READ, 2, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    issue(OP_TRANSLATE, 0, 0, 0, 0, 0, 0, 32'h7fffffff, 32'h80000000, 32'h00028000, 0);
    issue(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    issue(3'd5, 1, 1, 32'h12345678, 0, 0, 0, 1, 2, 3, 4);
    issue(3'd6, 2, 2, 0, 0, 0, 0, 0, 0, 0, 0);
    issue(3'd7, 3, 3, 0, 0, 0, 0, 0, 0, 0, 0);
    issue(OP_XFORM, 0, 0, 0, 0, 0, 0, 32'h00010000, 32'hffff0000, 32'h00020000,
          32'h00010000);
    issue(OP_READ, 3, 0, 0, 0, 0, 0, 0, 0, 0, 0);

    // random bursts with gaps
    while (sent < 1145) begin
      burst = $urandom_range(1, 12);
      repeat (burst) random_item();
      wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
      if (wait_n > 0) idle(wait_n);
    end
    start <= 0;

    while (rows_pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("ran %0d transactions, %0d results checked against the predicted matrix",
             sent, rows_seen);
    if (fail_count == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
